// File: sv/assert_macros.svh
// Assertion macros used by the encoder's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside of reset.
`define PQE_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pqe assertion failed");

// Condition that must never hold outside of reset.
`define PQE_NEVER(name, cond) `PQE_ASSERT(name, !(cond))

`endif

// File: sv/pqe_pkg.sv
// Package with sizes, payload types, register codes and control structs of the encoder.
`default_nettype none
package pqe_pkg;

	localparam int NUM_SUBSPACES = 8;
	localparam int NUM_CODEWORDS = 256;
	localparam int SUB_DIM       = 16;
	localparam int SAMPLE_WIDTH  = 16;

	localparam int SUB_W      = $clog2(NUM_SUBSPACES);
	localparam int WORD_W     = $clog2(NUM_CODEWORDS);
	localparam int ELEM_W     = $clog2(SUB_DIM);
	localparam int BOOK_DEPTH = NUM_SUBSPACES * NUM_CODEWORDS * SUB_DIM;
	localparam int ADDR_W     = $clog2(BOOK_DEPTH);

	// A difference of two samples has a magnitude below 2**SAMPLE_WIDTH.
	localparam int MAG_W  = SAMPLE_WIDTH;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int DIST_W = SQ_W + ELEM_W;

	localparam int SUBS_REG_W = 4;
	localparam int CW_REG_W   = 9;
	localparam int DIM_REG_W  = 5;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUBSPACES = 2'd0,
		REG_CODEWORDS = 2'd1,
		REG_SUB_DIM   = 2'd2
	} cfg_reg_t;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_VECTOR = 1'b1;

	typedef struct packed {
		logic                           req_type;
		logic [2:0]                     sub_index;
		logic [7:0]                     word_index;
		logic [3:0]                     elem_index;
		logic signed [SAMPLE_WIDTH-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [7:0] code;
		logic [2:0] subspace;
		logic       vector_done;
	} rsp_item_t;

	// Clamped register values, each held as its last valid index.
	typedef struct packed {
		logic [SUB_W-1:0]  sub_last;
		logic [WORD_W-1:0] word_last;
		logic [ELEM_W-1:0] dim_last;
	} cfg_t;

	typedef struct packed {
		logic              issue;
		logic              first_elem;
		logic              last_elem;
		logic              last_word;
		logic [WORD_W-1:0] word;
		logic [ELEM_W-1:0] elem;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic search_done;
		logic out_valid;
	} status_t;

endpackage
`default_nettype wire

// File: sv/pqe_cfg.sv
// Configuration registers of the encoder and their clamping to the supported ranges.
`default_nettype none
module pqe_cfg
	import pqe_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	logic [SUBS_REG_W-1:0] subs_q;
	logic [CW_REG_W-1:0]   words_q;
	logic [DIM_REG_W-1:0]  dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subs_q  <= SUBS_REG_W'(NUM_SUBSPACES);
			words_q <= CW_REG_W'(NUM_CODEWORDS);
			dim_q   <= DIM_REG_W'(SUB_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SUBSPACES: subs_q  <= cfg_data[SUBS_REG_W-1:0];
				REG_CODEWORDS: words_q <= cfg_data[CW_REG_W-1:0];
				REG_SUB_DIM:   dim_q   <= cfg_data[DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero acts as one and anything above the build size acts as the build size.
	always_comb begin
		if (subs_q == '0)
			cfg.sub_last = '0;
		else if (subs_q > SUBS_REG_W'(NUM_SUBSPACES))
			cfg.sub_last = SUB_W'(NUM_SUBSPACES - 1);
		else
			cfg.sub_last = SUB_W'(subs_q - 1'b1);

		if (words_q == '0)
			cfg.word_last = '0;
		else if (words_q > CW_REG_W'(NUM_CODEWORDS))
			cfg.word_last = WORD_W'(NUM_CODEWORDS - 1);
		else
			cfg.word_last = WORD_W'(words_q - 1'b1);

		if (dim_q == '0)
			cfg.dim_last = '0;
		else if (dim_q > DIM_REG_W'(SUB_DIM))
			cfg.dim_last = ELEM_W'(SUB_DIM - 1);
		else
			cfg.dim_last = ELEM_W'(dim_q - 1'b1);
	end

endmodule
`default_nettype wire

// File: sv/pqe_ctrl.sv
// Controller that sequences the codeword walk of one search and the result hand-off.
`default_nettype none
module pqe_ctrl
	import pqe_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire status_t status,
	input  wire logic    rsp_ready,
	output logic         req_ready,
	output cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] word_q;
	logic [ELEM_W-1:0] elem_q;
	logic              slot_free;

	assign slot_free = !status.out_valid || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);

	assign cmd.issue      = (state_q == ST_SEARCH);
	assign cmd.first_elem = (elem_q == '0);
	assign cmd.last_elem  = (elem_q == cfg.dim_last);
	assign cmd.last_word  = (word_q == cfg.word_last);
	assign cmd.word       = word_q;
	assign cmd.elem       = elem_q;
	assign cmd.load_out   = (state_q == ST_FINISH) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			word_q  <= '0;
			elem_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (status.start) begin
						state_q <= ST_SEARCH;
						word_q  <= '0;
						elem_q  <= '0;
					end
				end
				ST_SEARCH: begin
					// One codebook element is read per cycle, position by position.
					if (cmd.last_elem) begin
						elem_q <= '0;
						if (cmd.last_word)
							state_q <= ST_DRAIN;
						else
							word_q <= word_q + 1'b1;
					end else begin
						elem_q <= elem_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (status.search_done)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/pqe_datapath.sv
// Datapath: codebook memory, subvector buffer, distance pipeline, minimum search and result register.
`default_nettype none
module pqe_datapath
	import pqe_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      req_fire,
	input  wire req_item_t req_item,
	input  wire cmd_t      cmd,
	input  wire logic      rsp_ready,
	output status_t        status,
	output logic           rsp_valid,
	output rsp_item_t      rsp_item
);

	logic signed [SAMPLE_WIDTH-1:0] book_mem [BOOK_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] vec_buf  [SUB_DIM];

	logic              in_range;
	logic              buf_we;
	logic              book_we;
	logic [ADDR_W-1:0] load_addr;
	logic [ADDR_W-1:0] read_addr;

	logic [SUB_W-1:0] sub_q;
	logic             last_sub_q;

	logic signed [SAMPLE_WIDTH-1:0] cb_s1, vec_s1;
	logic              v_s1, first_s1, last_s1, lastw_s1;
	logic [WORD_W-1:0] word_s1;

	logic signed [SAMPLE_WIDTH:0] diff;
	logic [MAG_W-1:0]  mag_s2;
	logic              v_s2, first_s2, last_s2, lastw_s2;
	logic [WORD_W-1:0] word_s2;

	logic [SQ_W-1:0]   sq_s3;
	logic              v_s3, first_s3, last_s3, lastw_s3;
	logic [WORD_W-1:0] word_s3;

	logic [DIST_W-1:0] acc_q;
	logic              end_s4, lastw_s4;
	logic [WORD_W-1:0] word_s4;

	logic [DIST_W-1:0] best_q;
	logic [WORD_W-1:0] best_code_q;
	logic              done_q;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	assign in_range  = (req_item.sub_index <= cfg.sub_last) &&
		(req_item.elem_index <= cfg.dim_last);
	assign book_we   = req_fire && (req_item.req_type == REQ_LOAD);
	assign buf_we    = req_fire && (req_item.req_type == REQ_VECTOR) && in_range;
	assign load_addr = ADDR_W'((int'(req_item.sub_index) * NUM_CODEWORDS +
		int'(req_item.word_index)) * SUB_DIM + int'(req_item.elem_index));
	assign read_addr = ADDR_W'((int'(sub_q) * NUM_CODEWORDS + int'(cmd.word)) * SUB_DIM +
		int'(cmd.elem));

	assign status.start       = buf_we && (req_item.elem_index == cfg.dim_last);
	assign status.search_done = done_q;
	assign status.out_valid   = rsp_valid_q;

	always_ff @(posedge clk) begin
		if (book_we)
			book_mem[load_addr] <= req_item.value;
		cb_s1 <= book_mem[read_addr];
	end

	always_ff @(posedge clk) begin
		if (buf_we)
			vec_buf[req_item.elem_index] <= req_item.value;
		vec_s1 <= vec_buf[cmd.elem];
	end

	always_ff @(posedge clk) begin
		if (status.start) begin
			sub_q      <= req_item.sub_index;
			last_sub_q <= (req_item.sub_index == cfg.sub_last);
		end
	end

	assign diff = {cb_s1[SAMPLE_WIDTH-1], cb_s1} - {vec_s1[SAMPLE_WIDTH-1], vec_s1};

	// Payload stages of the distance pipeline.
	always_ff @(posedge clk) begin
		word_s1  <= cmd.word;
		first_s1 <= cmd.first_elem;
		last_s1  <= cmd.last_elem;
		lastw_s1 <= cmd.last_word;

		mag_s2   <= diff[SAMPLE_WIDTH] ? MAG_W'(-diff) : MAG_W'(diff);
		word_s2  <= word_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		lastw_s2 <= lastw_s1;

		sq_s3    <= mag_s2 * mag_s2;
		word_s3  <= word_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		lastw_s3 <= lastw_s2;

		if (v_s3)
			acc_q <= first_s3 ? DIST_W'(sq_s3) : acc_q + DIST_W'(sq_s3);
		word_s4  <= word_s3;
		lastw_s4 <= lastw_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			end_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			end_s4 <= v_s3 && last_s3;
			done_q <= end_s4 && lastw_s4;
		end
	end

	// Later codewords win ties, so the compare admits equality.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '1;
			best_code_q <= '0;
		end else if (status.start) begin
			best_q      <= '1;
			best_code_q <= '0;
		end else if (end_s4 && (acc_q <= best_q)) begin
			best_q      <= acc_q;
			best_code_q <= word_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.load_out)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.code        <= 8'(best_code_q);
			rsp_q.subspace    <= 3'(sub_q);
			rsp_q.vector_done <= last_sub_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule
`default_nettype wire

// File: sv/product_quantizer_encoder.sv
// The beat that completes a subvector starts a search, which reads one codebook element per cycle;
// input beats are held off until its code is loaded into the result register, and longer
// while an earlier code still waits in the result register.
// Reset restores the configuration to 8 / 256 / 16 and clears all control state;
// the codebook and the subvector buffer are not cleared.
`default_nettype none
`include "assert_macros.svh"
module product_quantizer_encoder
	import pqe_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire req_item_t             req_item,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output rsp_item_t                  rsp_item
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	logic    req_fire;

	assign req_fire = req_valid && req_ready;

	pqe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.status    (status),
		.rsp_ready (rsp_ready),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	pqe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_fire  (req_fire),
		.req_item  (req_item),
		.cmd       (cmd),
		.rsp_ready (rsp_ready),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

	`PQE_NEVER(a_no_issue_when_idle, cmd.issue && req_ready)
	`PQE_NEVER(a_no_done_when_idle, status.search_done && req_ready)
	`PQE_ASSERT(a_load_into_free_slot, cmd.load_out |-> (!rsp_valid || rsp_ready))
	`PQE_ASSERT(a_result_from_load, $rose(rsp_valid) |-> $past(cmd.load_out))

endmodule
`default_nettype wire

// File: bench/pqe_checker.sv
// Checker for the product quantizer encoder: mirrors the codebook and subvector, predicts codes.
`timescale 1ns / 1ps
module pqe_checker
	import pqe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_item_t             req_item,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  rsp_item_t             rsp_item,
	output int                    fail_count,
	output int                    codes_pending
);

	localparam longint unsigned DIST_CAP = (64'd1 << 40) - 64'd1;

	logic signed [SAMPLE_WIDTH-1:0] book_copy [BOOK_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] subvec_copy [SUB_DIM];
	logic [SUBS_REG_W-1:0] subs_reg;
	logic [CW_REG_W-1:0]   words_reg;
	logic [DIM_REG_W-1:0]  dim_reg;
	rsp_item_t             code_queue [$];

	function automatic int unsigned clamp_count(int unsigned raw, int unsigned limit);
		if (raw < 1) return 1;
		if (raw > limit) return limit;
		return raw;
	endfunction

	// Squared distance to every codeword in use; on equal distances the later index wins.
	function automatic logic [7:0] nearest_code(int unsigned sub, int unsigned n_word,
		int unsigned n_dim);
		longint unsigned best_dist;
		longint unsigned sum_sq;
		longint          diff;
		int unsigned     best;
		best_dist = DIST_CAP;
		best = 0;
		for (int unsigned w = 0; w < n_word; w++) begin
			sum_sq = 0;
			for (int unsigned e = 0; e < n_dim; e++) begin
				diff = longint'(book_copy[(sub * NUM_CODEWORDS + w) * SUB_DIM + e])
					- longint'(subvec_copy[e]);
				sum_sq += longint'(diff * diff);
				if (sum_sq > DIST_CAP) sum_sq = DIST_CAP;
			end
			if (sum_sq <= best_dist) begin
				best_dist = sum_sq;
				best = w;
			end
		end
		return best[7:0];
	endfunction

	task automatic report(string field, int unsigned want, int unsigned got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int unsigned n_sub;
		int unsigned n_word;
		int unsigned n_dim;
		rsp_item_t   want;
		if (!arst_n) begin
			subs_reg = 4'd8;
			words_reg = 9'd256;
			dim_reg = 5'd16;
			code_queue.delete();
			fail_count = 0;
			codes_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SUBSPACES: subs_reg = cfg_data[SUBS_REG_W-1:0];
					REG_CODEWORDS: words_reg = cfg_data[CW_REG_W-1:0];
					REG_SUB_DIM: dim_reg = cfg_data[DIM_REG_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				n_sub = clamp_count(subs_reg, NUM_SUBSPACES);
				n_word = clamp_count(words_reg, NUM_CODEWORDS);
				n_dim = clamp_count(dim_reg, SUB_DIM);
				if (req_item.req_type == REQ_LOAD) begin
					book_copy[(int'(req_item.sub_index) * NUM_CODEWORDS
						+ int'(req_item.word_index)) * SUB_DIM
						+ int'(req_item.elem_index)] = req_item.value;
				end else if (req_item.sub_index < n_sub && req_item.elem_index < n_dim) begin
					subvec_copy[req_item.elem_index] = req_item.value;
					// The beat at the last position of the subvector starts a search.
					if (req_item.elem_index == n_dim - 1) begin
						want.code = nearest_code(req_item.sub_index, n_word, n_dim);
						want.subspace = req_item.sub_index;
						want.vector_done = (req_item.sub_index == n_sub - 1);
						code_queue.push_back(want);
					end
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (code_queue.size() == 0) begin
					$display("%0t: code beat with none expected, actual code %0d subspace %0d",
						$time, rsp_item.code, rsp_item.subspace);
					fail_count++;
				end else begin
					want = code_queue.pop_front();
					if (want.code !== rsp_item.code)
						report("code", want.code, rsp_item.code);
					if (want.subspace !== rsp_item.subspace)
						report("subspace", want.subspace, rsp_item.subspace);
					if (want.vector_done !== rsp_item.vector_done)
						report("vector_done", want.vector_done, rsp_item.vector_done);
				end
			end
			codes_pending = code_queue.size();
		end
	end

endmodule

// File: bench/testbench.sv
// Top of the encoder testbench: clock, reset, register writes, request stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import pqe_pkg::*;

	localparam int unsigned RUN_LIMIT     = 5_000_000;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned PHASE_ITEMS   = 45;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_THREE_OF_FOUR,
		READY_LONG_STALL
	} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_item_t             req_item = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_item_t             rsp_item;
	int                    fail_count;
	int                    codes_pending;
	int unsigned           cycle_count = 0;

	// Which codebook entries and subvector positions hold data, so no search reads an empty one.
	bit          book_written [BOOK_DEPTH];
	bit          subvec_written [SUB_DIM];
	int unsigned n_sub = NUM_SUBSPACES;
	int unsigned n_word = NUM_CODEWORDS;
	int unsigned n_dim = SUB_DIM;
	int unsigned burst_left = 0;
	int unsigned next_sub = 0;
	int unsigned phase_items = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int unsigned ready_tick = 0;

	always #2 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	product_quantizer_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item)
	);

	pqe_checker watcher (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item),
		.fail_count(fail_count),
		.codes_pending(codes_pending)
	);

	always @(negedge clk) begin
		ready_tick++;
		if (ready_tick % 256 == 0) ready_mode = ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			READY_ALWAYS: rsp_ready <= 1'b1;
			READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
			READY_THREE_OF_FOUR: rsp_ready <= (ready_tick % 4 != 0);
			default: rsp_ready <= (ready_tick % 24 >= 20);
		endcase
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int unsigned bounded(int unsigned raw, int unsigned limit);
		if (raw < 1) return 1;
		if (raw > limit) return limit;
		return raw;
	endfunction

	// Extremes and a narrow band near zero show up often, so ties and saturation-free
	// worst cases occur as well as plain random samples.
	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
			2, 3: return SAMPLE_WIDTH'($urandom_range(0, 8) - 4);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	task automatic send_req(input logic kind, input int unsigned sub, word, elem,
		input logic signed [SAMPLE_WIDTH-1:0] sample);
		req_item_t   beat;
		int unsigned gap;
		beat.req_type = kind;
		beat.sub_index = sub[2:0];
		beat.word_index = word[7:0];
		beat.elem_index = elem[3:0];
		beat.value = sample;
		if (kind == REQ_LOAD) begin
			book_written[(sub * NUM_CODEWORDS + word) * SUB_DIM + elem] = 1'b1;
			phase_items++;
		end else if (sub < n_sub && elem < n_dim) begin
			subvec_written[elem] = 1'b1;
			phase_items++;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 15);
			if (gap < 4) gap = 0;
			else if (gap < 15) gap = $urandom_range(1, 4);
			else gap = $urandom_range(10, 80);
			repeat (gap) begin
				@(negedge clk);
				req_valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_item <= beat;
		do @(posedge clk); while (!req_ready);
		burst_left--;
	endtask

	// Stop sending, let every expected code arrive, then give the last search time to end.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		burst_left = 0;
		while (codes_pending != 0) @(negedge clk);
		repeat (n_word * n_dim + 16) @(posedge clk);
	endtask

	task automatic configure(input int unsigned subs_raw, words_raw, dim_raw);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SUBSPACES;
		cfg_data <= CFG_DATA_W'(subs_raw);
		@(negedge clk);
		cfg_index <= REG_CODEWORDS;
		cfg_data <= CFG_DATA_W'(words_raw);
		@(negedge clk);
		cfg_index <= REG_SUB_DIM;
		cfg_data <= CFG_DATA_W'(dim_raw);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_sub = bounded(subs_raw, NUM_SUBSPACES);
		n_word = bounded(words_raw, NUM_CODEWORDS);
		n_dim = bounded(dim_raw, SUB_DIM);
		next_sub = 0;
	endtask

	// Loads every entry a search may read under the current settings that holds nothing yet.
	task automatic fill_book(input bit patterned);
		logic signed [SAMPLE_WIDTH-1:0] level [4] = '{16'sh7FFF, 16'sh0000, 16'sh8000, 16'sh0000};
		for (int unsigned s = 0; s < n_sub; s++)
			for (int unsigned w = 0; w < n_word; w++)
				for (int unsigned e = 0; e < n_dim; e++)
					if (!book_written[(s * NUM_CODEWORDS + w) * SUB_DIM + e])
						send_req(REQ_LOAD, s, w, e, patterned ? level[w % 4] : pick_sample());
		phase_items = 0;
	endtask

	// A whole subvector; sometimes shuffled, but the last position always comes last.
	task automatic send_vector(input int unsigned sub);
		int unsigned order [SUB_DIM];
		int unsigned pick;
		int unsigned held;
		for (int unsigned i = 0; i < n_dim; i++) order[i] = i;
		if ($urandom_range(0, 2) == 0) begin
			for (int i = int'(n_dim) - 2; i > 0; i--) begin
				pick = $urandom_range(0, i);
				held = order[i];
				order[i] = order[pick];
				order[pick] = held;
			end
		end
		for (int unsigned i = 0; i < n_dim; i++)
			send_req(REQ_VECTOR, sub, $urandom_range(0, 255), order[i], pick_sample());
	endtask

	task automatic send_noise();
		int unsigned sub;
		int unsigned elem;
		case ($urandom_range(0, 2))
			0: send_req(REQ_LOAD, $urandom_range(0, 7), $urandom_range(0, 255),
				$urandom_range(0, 15), pick_sample());
			1: begin
				if (n_sub < NUM_SUBSPACES && (n_dim == SUB_DIM || $urandom_range(0, 1)))
					send_req(REQ_VECTOR, $urandom_range(n_sub, NUM_SUBSPACES - 1),
						$urandom_range(0, 255), $urandom_range(0, SUB_DIM - 1), pick_sample());
				else if (n_dim < SUB_DIM)
					send_req(REQ_VECTOR, $urandom_range(0, NUM_SUBSPACES - 1),
						$urandom_range(0, 255), $urandom_range(n_dim, SUB_DIM - 1), pick_sample());
				else
					send_req(REQ_LOAD, $urandom_range(0, 7), $urandom_range(0, 255),
						$urandom_range(0, 15), pick_sample());
			end
			default: begin
				// A lone element leaves the rest of the subvector stale for the next search.
				sub = $urandom_range(0, n_sub - 1);
				elem = $urandom_range(0, n_dim - 1);
				if (elem == n_dim - 1) begin
					for (int unsigned e = 0; e + 1 < n_dim; e++) begin
						if (!subvec_written[e]) begin
							elem = e;
							break;
						end
					end
				end
				send_req(REQ_VECTOR, sub, $urandom_range(0, 255), elem, pick_sample());
			end
		endcase
	endtask

	task automatic run_phase(input int unsigned subs_raw, words_raw, dim_raw);
		drain();
		configure(subs_raw, words_raw, dim_raw);
		fill_book(1'b0);
		while (phase_items < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 3) == 0) begin
					send_vector($urandom_range(0, n_sub - 1));
				end else begin
					send_vector(next_sub);
					next_sub = (next_sub + 1) % n_sub;
				end
			end else begin
				send_noise();
			end
		end
	endtask

	initial begin
		int unsigned subs_raw;
		int unsigned words_raw;
		int unsigned dim_raw;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Tiny codebook: codewords alternate between full scale, zero and negative full scale,
		// so two zero codewords tie and the later one must win.
		configure(2, 4, 3);
		fill_book(1'b1);
		send_req(REQ_VECTOR, 0, 255, 0, 16'sh0000);
		send_req(REQ_VECTOR, 0, 0, 1, 16'sh0000);
		send_req(REQ_VECTOR, 0, 0, 2, 16'sh0000);
		send_req(REQ_VECTOR, 1, 255, 0, 16'sh7FFF);
		send_req(REQ_VECTOR, 1, 0, 1, 16'sh7FFF);
		send_req(REQ_VECTOR, 1, 0, 2, 16'sh7FFF);
		send_req(REQ_VECTOR, 1, 0, 2, 16'sh8000);
		// Vector elements outside the subspaces or positions in use are dropped.
		send_req(REQ_VECTOR, 2, 0, 0, 16'sh1234);
		send_req(REQ_VECTOR, 7, 0, 2, 16'sh7FFF);
		send_req(REQ_VECTOR, 0, 0, 3, 16'sh8000);
		send_req(REQ_VECTOR, 0, 0, 15, 16'sh0001);
		send_req(REQ_LOAD, 7, 255, 15, 16'sh8000);
		send_req(REQ_LOAD, 0, 2, 1, 16'sh0001);
		send_req(REQ_VECTOR, 0, 0, 2, 16'sh8000);
		send_req(REQ_VECTOR, 1, 0, 0, 16'sh8000);
		send_req(REQ_VECTOR, 1, 0, 1, 16'sh8000);
		send_req(REQ_VECTOR, 1, 0, 2, 16'sh8000);

		// Zero in every register counts as one.
		drain();
		configure(0, 0, 0);
		send_req(REQ_VECTOR, 0, 0, 0, 16'shFFFF);
		send_req(REQ_VECTOR, 1, 0, 0, 16'sh7FFF);

		// Values above the limits clamp to the full sizes. Only the two subspaces
		// searched here get their codewords loaded.
		drain();
		configure(15, 511, 1);
		for (int unsigned w = 0; w < NUM_CODEWORDS; w++) begin
			if (!book_written[w * SUB_DIM])
				send_req(REQ_LOAD, 0, w, 0, pick_sample());
			if (!book_written[(7 * NUM_CODEWORDS + w) * SUB_DIM])
				send_req(REQ_LOAD, 7, w, 0, pick_sample());
		end
		send_req(REQ_VECTOR, 0, 0, 0, 16'sh7FFF);
		send_req(REQ_VECTOR, 7, 255, 0, 16'sh8000);

		run_phase(9, 2, 31);
		run_phase(8, 32, 1);
		run_phase(1, 3, 16);
		repeat (RANDOM_PHASES) begin
			case ($urandom_range(0, 9))
				0: begin
					subs_raw = $urandom_range(1, 2);
					words_raw = $urandom_range(64, 256);
					dim_raw = 1;
				end
				1: begin
					subs_raw = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
					words_raw = $urandom_range(1, 8);
					dim_raw = $urandom_range(1, 8);
				end
				2: begin
					subs_raw = 1;
					words_raw = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
					dim_raw = 1;
				end
				3: begin
					subs_raw = $urandom_range(1, 4);
					words_raw = $urandom_range(1, 4);
					dim_raw = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
				end
				default: begin
					subs_raw = $urandom_range(1, 8);
					words_raw = $urandom_range(1, 16);
					dim_raw = $urandom_range(1, 16);
				end
			endcase
			run_phase(subs_raw, words_raw, dim_raw);
		end

		drain();
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/pqe_pkg.sv
sv/pqe_cfg.sv
sv/pqe_ctrl.sv
sv/pqe_datapath.sv
sv/product_quantizer_encoder.sv
bench/pqe_checker.sv
bench/testbench.sv
